FILE: sv/drt_pkg.sv
// Shared constants and types for the dirty rectangle tracker.
package drt_pkg;

    localparam int MAX_SLOTS   = 8;
    localparam int LAYER_TOTAL = 2;
    localparam int LAYER_W     = 1;
    localparam int SLOT_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W       = $clog2(MAX_SLOTS + 1);
    localparam int ADDR_W      = LAYER_W + SLOT_W;
    localparam int STORE_DEPTH = LAYER_TOTAL << SLOT_W;
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_W-1:0] SCREEN_LIMIT = 12'd2048;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd320;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd240;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

    localparam logic OP_MARK  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        MS_APPENDED = 2'd0,
        MS_COVERED  = 2'd1,
        MS_FOLDED   = 2'd2,
        MS_CLIPPED  = 2'd3
    } mark_status_t;

    typedef struct packed {
        logic [10:0] x;
        logic [10:0] y;
        logic [11:0] w;
        logic [11:0] h;
    } box_t;

    localparam int BOX_W = $bits(box_t);

endpackage

FILE: sv/dirty_rectangle_tracker.sv
// Dirty rectangle tracker top level: per-layer rectangle lists in one RAM.
//
// Input words (s_*) carry a mark or a clear for one layer; result words
// (m_*) come out on a valid/ready channel with an output register, so a
// new input word is taken while a result still waits for the receiver.
// A mark clips its rectangle to the screen on acceptance, then scans the
// layer's list one slot a cycle through the RAM read port, stopping on
// the first stored rectangle that contains it; it then appends, or folds
// into the last slot when the list is full. A mark returns one status
// word (appended, covered, folded or clipped); a clipped-away mark skips
// the scan. A clear returns one word per stored rectangle, one per cycle
// while the receiver takes them, or a single empty word for an empty
// list. One item is in flight at a time; s_ready rises the cycle after
// the item's last word is loaded. The rate is set by the single RAM
// read port. Reset empties all lists (counts to zero), sets the screen
// size to 320 x 240 and drops any pending result. While the receiver
// stalls the block holds its current result; a scan goes on, and the
// block waits only when it has its next word to load.
module dirty_rectangle_tracker
    import drt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_operation,
    input  logic                 s_layer,
    input  logic signed [15:0]   s_rect_x,
    input  logic signed [15:0]   s_rect_y,
    input  logic signed [15:0]   s_rect_w,
    input  logic signed [15:0]   s_rect_h,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_mark_status,
    output logic                 m_rect_valid,
    output logic [10:0]          m_out_x,
    output logic [10:0]          m_out_y,
    output logic [11:0]          m_out_w,
    output logic [11:0]          m_out_h,
    output logic                 m_has_content,
    output logic                 m_last
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]   scr_w_reg, scr_h_reg;
    logic [CNT_W-1:0]   cnt_reg [LAYER_TOTAL];
    logic [LAYER_W-1:0] lay_reg, lay_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               cmp_vld_reg, cmp_vld_next;
    box_t               box_reg, box_next;
    mark_status_t       res_status_reg, res_status_next;
    logic               res_content_reg, res_content_next;

    logic               m_valid_reg;
    logic [1:0]         m_status_reg;
    logic               m_rvalid_reg, m_content_reg, m_last_reg;
    box_t               m_box_reg;

    logic               out_free, out_load;
    logic [1:0]         out_status;
    logic               out_rvalid, out_content, out_last;
    box_t               out_box;

    logic               cnt_clr, cnt_inc;
    logic [CNT_W-1:0]   cnt_cur;

    logic               rd_en, wr_en;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;
    box_t               rd_box, wr_box;
    logic [BOX_W-1:0]   rd_data;

    // clipping
    logic [CFG_W-1:0]   sw, sh;
    logic signed [18:0] ix, iy, iw, ih, xl, yl, wl, hl, rgt, bot, w2, h2, sw19, sh19;
    logic               kept;
    box_t               clip_box;

    // containment and folding
    logic [12:0]        c_rx, c_by, r_rx, r_by, f_rx, f_by;
    logic [10:0]        f_x, f_y;
    logic               hit;
    box_t               fold_box;

    assign sw   = (scr_w_reg > SCREEN_LIMIT) ? SCREEN_LIMIT : scr_w_reg;
    assign sh   = (scr_h_reg > SCREEN_LIMIT) ? SCREEN_LIMIT : scr_h_reg;
    assign sw19 = signed'({7'd0, sw});
    assign sh19 = signed'({7'd0, sh});

    always_comb begin
        ix   = {{3{s_rect_x[15]}}, s_rect_x};
        iy   = {{3{s_rect_y[15]}}, s_rect_y};
        iw   = {{3{s_rect_w[15]}}, s_rect_w};
        ih   = {{3{s_rect_h[15]}}, s_rect_h};
        xl   = ix[18] ? '0 : ix;
        yl   = iy[18] ? '0 : iy;
        wl   = ix[18] ? iw + ix : iw;
        hl   = iy[18] ? ih + iy : ih;
        rgt  = xl + wl;
        bot  = yl + hl;
        w2   = (rgt > sw19) ? sw19 - xl : wl;
        h2   = (bot > sh19) ? sh19 - yl : hl;
        kept = !w2[18] && (w2 != '0) && !h2[18] && (h2 != '0);
        clip_box.x = xl[10:0];
        clip_box.y = yl[10:0];
        clip_box.w = w2[11:0];
        clip_box.h = h2[11:0];
    end

    assign rd_box = box_t'(rd_data);

    always_comb begin
        c_rx = {2'd0, box_reg.x} + {1'b0, box_reg.w};
        c_by = {2'd0, box_reg.y} + {1'b0, box_reg.h};
        r_rx = {2'd0, rd_box.x} + {1'b0, rd_box.w};
        r_by = {2'd0, rd_box.y} + {1'b0, rd_box.h};
        hit  = cmp_vld_reg && (box_reg.x >= rd_box.x) && (box_reg.y >= rd_box.y)
               && (c_rx <= r_rx) && (c_by <= r_by);
        f_rx = (r_rx > c_rx) ? r_rx : c_rx;
        f_by = (r_by > c_by) ? r_by : c_by;
        f_x  = (box_reg.x < rd_box.x) ? box_reg.x : rd_box.x;
        f_y  = (box_reg.y < rd_box.y) ? box_reg.y : rd_box.y;
        fold_box.x = f_x;
        fold_box.y = f_y;
        fold_box.w = 12'(f_rx - {2'd0, f_x});
        fold_box.h = 12'(f_by - {2'd0, f_y});
    end

    assign cnt_cur  = cnt_reg[s_layer];
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next       = state_reg;
        lay_next         = lay_reg;
        n_next           = n_reg;
        idx_next         = idx_reg;
        cmp_vld_next     = 1'b0;
        box_next         = box_reg;
        res_status_next  = res_status_reg;
        res_content_next = res_content_reg;
        cnt_clr          = 1'b0;
        cnt_inc          = 1'b0;
        rd_en            = 1'b0;
        rd_addr          = {lay_reg, idx_reg[SLOT_W-1:0]};
        wr_en            = 1'b0;
        wr_addr          = {lay_reg, n_reg[SLOT_W-1:0]};
        wr_box           = box_reg;
        out_load         = 1'b0;
        out_status       = MS_APPENDED;
        out_rvalid       = 1'b0;
        out_box          = '0;
        out_content      = 1'b0;
        out_last         = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    lay_next = s_layer;
                    n_next   = cnt_cur;
                    if (s_operation == OP_MARK) begin
                        box_next = clip_box;
                        idx_next = '0;
                        if (!kept) begin
                            res_status_next  = MS_CLIPPED;
                            res_content_next = (cnt_cur != '0);
                            state_next       = ST_RESP;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end else begin
                        cnt_clr = 1'b1;
                        if (cnt_cur == '0) begin
                            res_status_next  = MS_APPENDED;
                            res_content_next = 1'b0;
                            state_next       = ST_RESP;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = {s_layer, {SLOT_W{1'b0}}};
                            idx_next   = CNT_W'(1);
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_SCAN: begin
                res_content_next = 1'b1;
                if (hit) begin
                    res_status_next = MS_COVERED;
                    state_next      = ST_RESP;
                end else if (idx_reg < n_reg) begin
                    rd_en        = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                end else if (n_reg == CNT_W'(MAX_SLOTS)) begin
                    // rd_data holds the last slot here
                    wr_en           = 1'b1;
                    wr_addr         = {lay_reg, SLOT_W'(MAX_SLOTS - 1)};
                    wr_box          = fold_box;
                    res_status_next = MS_FOLDED;
                    state_next      = ST_RESP;
                end else begin
                    wr_en           = 1'b1;
                    cnt_inc         = 1'b1;
                    res_status_next = MS_APPENDED;
                    state_next      = ST_RESP;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_rvalid = 1'b1;
                    out_box    = rd_box;
                    out_last   = (idx_reg == n_reg);
                    if (idx_reg != n_reg) begin
                        rd_en    = 1'b1;
                        idx_next = idx_reg + 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    out_status  = res_status_reg;
                    out_content = res_content_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            scr_w_reg   <= WIDTH_RESET;
            scr_h_reg   <= HEIGHT_RESET;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < LAYER_TOTAL; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SCREEN_WIDTH:  scr_w_reg <= cfg_data;
                    CFG_SCREEN_HEIGHT: scr_h_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (cnt_clr) begin
                cnt_reg[s_layer] <= '0;
            end else if (cnt_inc) begin
                cnt_reg[lay_reg] <= n_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lay_reg         <= lay_next;
        n_reg           <= n_next;
        idx_reg         <= idx_next;
        cmp_vld_reg     <= cmp_vld_next;
        box_reg         <= box_next;
        res_status_reg  <= res_status_next;
        res_content_reg <= res_content_next;
        if (out_load) begin
            m_status_reg  <= out_status;
            m_rvalid_reg  <= out_rvalid;
            m_box_reg     <= out_box;
            m_content_reg <= out_content;
            m_last_reg    <= out_last;
        end
    end

    drt_ram #(
        .WIDTH(BOX_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_box),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign m_valid       = m_valid_reg;
    assign m_mark_status = m_status_reg;
    assign m_rect_valid  = m_rvalid_reg;
    assign m_out_x       = m_box_reg.x;
    assign m_out_y       = m_box_reg.y;
    assign m_out_w       = m_box_reg.w;
    assign m_out_h       = m_box_reg.h;
    assign m_has_content = m_content_reg;
    assign m_last        = m_last_reg;

endmodule

FILE: sv/drt_ram.sv
// Generic simple dual-port RAM with registered read.
module drt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/drt_checker.sv
// Port-level assertions for the dirty rectangle tracker, bound to the top level.
module drt_checker
    import drt_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [1:0]           m_mark_status,
    input logic                 m_rect_valid,
    input logic [10:0]          m_out_x,
    input logic [10:0]          m_out_y,
    input logic [11:0]          m_out_w,
    input logic [11:0]          m_out_h,
    input logic                 m_has_content,
    input logic                 m_last
);

    a_reset_drops: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x) && $stable(m_out_w)
            && $stable(m_last) && $stable(m_mark_status))
        else $error("stalled result word changed");

    a_clear_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rect_valid |-> !m_has_content && m_mark_status == MS_APPENDED
            && m_out_w != '0 && m_out_h != '0)
        else $error("rectangle word malformed");

    a_empty_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rect_valid |-> m_last && m_out_x == '0 && m_out_y == '0
            && m_out_w == '0 && m_out_h == '0)
        else $error("status word carries rectangle fields");

    a_mark_content: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_mark_status == MS_COVERED || m_mark_status == MS_FOLDED)
            |-> m_has_content)
        else $error("covered or folded mark without content");

endmodule

bind dirty_rectangle_tracker drt_checker u_drt_checker (.*);
